// ===== sv/psf_pkg.sv =====
// Package for the PCM sample formatter: width codes, register indexes,
// scale constants and the per-stage transaction structures.
// Depends on nothing; the decode, multiply, round, pack and top-level files import it.
`default_nettype none

package psf_pkg;

   localparam logic [2:0] NB_ONE   = 3'd1;
   localparam logic [2:0] NB_TWO   = 3'd2;
   localparam logic [2:0] NB_THREE = 3'd3;
   localparam logic [2:0] NB_FOUR  = 3'd4;

   localparam logic [1:0] CSR_OUT_BYTES   = 2'd0;
   localparam logic [1:0] CSR_FLOAT_MODE  = 2'd1;
   localparam logic [1:0] CSR_SOURCE_BITS = 2'd2;

   localparam logic [2:0] RESET_OUT_BYTES    = 3'd2;
   localparam logic [5:0] RESET_SOURCE_BITS  = 6'd16;

   typedef struct packed {
      logic       last;
      logic       fmode;
      logic [2:0] nbytes;
   } ctrl_type;

   typedef struct packed {
      ctrl_type    ctrl;
      logic        sign;
      logic        zero;
      logic        nan;
      logic [7:0]  expo;
      logic [23:0] man;
      logic [31:0] kconst;
      logic [5:0]  kbits;
      logic [31:0] ival;
      logic [4:0]  ishift;
   } dec_type;

   typedef struct packed {
      ctrl_type    ctrl;
      logic        sign;
      logic        zero;
      logic        nan;
      logic [7:0]  expo;
      logic [55:0] prod;
      logic [5:0]  kbits;
      logic [31:0] ival;
   } mul_type;

   typedef struct packed {
      ctrl_type    ctrl;
      logic        sign;
      logic        nan;
      logic [32:0] mag;
      logic [47:0] pfix;
      logic [31:0] ival;
   } rnd_type;

   typedef struct packed {
      ctrl_type    ctrl;
      logic        nan;
      logic [48:0] sum;
      logic [31:0] res;
   } sum_type;

   // Single-precision scale factors; 2147483647.0f rounds to 2^31.
   function automatic logic [31:0] scale_const(input logic [2:0] nb);
      logic [31:0] k;
      unique case (nb)
         NB_ONE:   k = 32'd127;
         NB_TWO:   k = 32'd32767;
         NB_THREE: k = 32'd8388607;
         NB_FOUR:  k = 32'h8000_0000;
         default:  k = 32'd0;
      endcase
      return k;
   endfunction

   // Bit length of the scale factor above.
   function automatic logic [5:0] scale_bits(input logic [2:0] nb);
      logic [5:0] b;
      unique case (nb)
         NB_ONE:   b = 6'd7;
         NB_TWO:   b = 6'd15;
         NB_THREE: b = 6'd23;
         NB_FOUR:  b = 6'd32;
         default:  b = 6'd7;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== sv/psf_decode.sv =====
// First stage: unpacks and clamps the float operand, clamps the integer
// operand and picks the scale factor and integer shift.
// Depends on psf_pkg.
`default_nettype none

module psf_decode import psf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        adv,
   input  wire logic        in_valid,
   input  wire logic [31:0] in_bits,
   input  wire logic        in_last,
   input  wire logic [2:0]  out_bytes,
   input  wire logic        float_mode,
   input  wire logic [5:0]  source_bits,
   output logic             out_valid,
   output dec_type          out_data
);

   logic    valid_ff;
   dec_type data_ff;
   dec_type data_in;

   always_comb begin
      logic [7:0]         expo;
      logic [22:0]        frac;
      logic               big;
      logic signed [31:0] sv;
      logic [5:0]         diff;
      expo = in_bits[30:23];
      frac = in_bits[22:0];
      big  = (expo > 8'd127) || ((expo == 8'd127) && (frac != 23'd0));
      sv   = $signed(in_bits);
      diff = source_bits - 6'd16;

      data_in.ctrl.last   = in_last;
      data_in.ctrl.fmode  = float_mode;
      data_in.ctrl.nbytes = out_bytes;
      data_in.sign   = in_bits[31];
      data_in.nan    = (&expo) && (frac != 23'd0);
      data_in.zero   = (expo == 8'd0);
      data_in.expo   = big ? 8'd127 : expo;
      data_in.man    = big ? 24'h80_0000 : {1'b1, frac};
      data_in.kconst = scale_const(out_bytes);
      data_in.kbits  = scale_bits(out_bytes);

      data_in.ival   = in_bits;
      data_in.ishift = 5'd0;
      if ((out_bytes == NB_ONE) || (out_bytes == NB_TWO)) begin
         if (sv > 32'sd32767) begin
            data_in.ival = 32'd32767;
         end else if (sv < -32'sd32768) begin
            data_in.ival = 32'hFFFF_8000;
         end
         if (source_bits > 6'd16) begin
            data_in.ishift = (diff > 6'd31) ? 5'd31 : diff[4:0];
         end
      end else if (out_bytes == NB_THREE) begin
         if (sv > 32'sd8388607) begin
            data_in.ival = 32'd8388607;
         end else if (sv < -32'sd8388608) begin
            data_in.ival = 32'hFF80_0000;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== sv/psf_multiply.sv =====
// Second stage: exact product of mantissa and scale factor, and the
// arithmetic shift of the integer operand.
// Depends on psf_pkg.
`default_nettype none

module psf_multiply import psf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic adv,
   input  wire logic in_valid,
   input  dec_type   in_data,
   output logic      out_valid,
   output mul_type   out_data
);

   logic    valid_ff;
   mul_type data_ff;
   mul_type data_in;

   always_comb begin
      data_in.ctrl  = in_data.ctrl;
      data_in.sign  = in_data.sign;
      data_in.zero  = in_data.zero;
      data_in.nan   = in_data.nan;
      data_in.expo  = in_data.expo;
      data_in.kbits = in_data.kbits;
      data_in.prod  = 56'(in_data.man) * 56'(in_data.kconst);
      data_in.ival  = 32'($signed(in_data.ival) >>> in_data.ishift);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== sv/psf_round.sv =====
// Third stage: rounds the product to single precision and aligns it, both
// as a truncated integer magnitude and as a fixed-point value for the offset.
// Depends on psf_pkg.
`default_nettype none

module psf_round import psf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic adv,
   input  wire logic in_valid,
   input  mul_type   in_data,
   output logic      out_valid,
   output rnd_type   out_data
);

   logic    valid_ff;
   rnd_type data_ff;
   rnd_type data_in;

   always_comb begin
      logic [5:0]        t;
      logic [5:0]        sh;
      logic [55:0]       shifted;
      logic [55:0]       mask;
      logic              guard;
      logic              sticky;
      logic [24:0]       rr;
      logic signed [9:0] s;
      logic signed [9:0] ns;
      logic signed [9:0] psh;
      logic signed [9:0] np;
      t       = in_data.prod[6'd23 + in_data.kbits] ? (6'd23 + in_data.kbits)
                                                    : (6'd22 + in_data.kbits);
      sh      = t - 6'd23;
      shifted = in_data.prod >> sh;
      guard   = in_data.prod[sh - 6'd1];
      mask    = (56'd1 << (sh - 6'd1)) - 56'd1;
      sticky  = |(in_data.prod & mask);
      rr      = {1'b0, shifted[23:0]} + 25'(guard & (sticky | shifted[0]));
      s       = $signed({4'b0, t}) + $signed({2'b0, in_data.expo}) - 10'sd173;
      ns      = -s;
      psh     = s + 10'sd41;
      np      = -psh;

      data_in.ctrl = in_data.ctrl;
      data_in.sign = in_data.sign;
      data_in.nan  = in_data.nan;
      data_in.ival = in_data.ival;

      if (in_data.zero) begin
         data_in.mag = 33'd0;
      end else if (s >= 10'sd0) begin
         data_in.mag = 33'(rr) << s[3:0];
      end else if (ns >= 10'sd25) begin
         data_in.mag = 33'd0;
      end else begin
         data_in.mag = 33'(rr >> ns[4:0]);
      end

      if (in_data.zero) begin
         data_in.pfix = 48'd0;
      end else if (psh >= 10'sd0) begin
         data_in.pfix = 48'(rr) << psh[5:0];
      end else if (np >= 10'sd25) begin
         data_in.pfix = {47'd0, |rr};
      end else begin
         data_in.pfix = 48'(rr >> np[4:0])
                      | 48'(|(rr & ((25'd1 << np[4:0]) - 25'd1)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== sv/psf_pack.sv =====
// Fourth and fifth stages: adds the one-byte offset and rounds that sum,
// applies sign, saturation and width masks, and holds the output register.
// Depends on psf_pkg.
`default_nettype none

module psf_pack import psf_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   adv,
   input  wire logic   in_valid,
   input  rnd_type     in_data,
   output logic        out_valid,
   output logic [31:0] out_word,
   output logic        out_last
);

   localparam logic [48:0] OFFSET = 49'd128 << 41;

   logic        sum_valid_ff;
   sum_type     sum_ff;
   sum_type     sum_in;
   logic        valid_ff;
   logic [31:0] word_ff;
   logic [31:0] word_in;
   logic        last_ff;

   always_comb begin
      logic [32:0] smag;
      smag = in_data.sign ? (33'd0 - in_data.mag) : in_data.mag;
      sum_in.ctrl = in_data.ctrl;
      sum_in.nan  = in_data.nan;
      sum_in.sum  = in_data.sign ? (OFFSET - {1'b0, in_data.pfix})
                                 : (OFFSET + {1'b0, in_data.pfix});
      sum_in.res  = 32'd0;
      if (in_data.ctrl.fmode) begin
         if (!in_data.nan) begin
            unique case (in_data.ctrl.nbytes)
               NB_TWO:   sum_in.res = {16'd0, smag[15:0]};
               NB_THREE: sum_in.res = {8'd0, smag[23:0]};
               NB_FOUR: begin
                  if (!in_data.sign && (in_data.mag[32:31] != 2'd0)) begin
                     sum_in.res = 32'h7FFF_FFFF;
                  end else begin
                     sum_in.res = smag[31:0];
                  end
               end
               default:  sum_in.res = 32'd0;
            endcase
         end
      end else begin
         unique case (in_data.ctrl.nbytes)
            NB_ONE:   sum_in.res = {24'd0, in_data.ival[7:0] + 8'd128};
            NB_TWO:   sum_in.res = {16'd0, in_data.ival[15:0]};
            NB_THREE: sum_in.res = {8'd0, in_data.ival[23:0]};
            NB_FOUR:  sum_in.res = in_data.ival;
            default:  sum_in.res = 32'd0;
         endcase
      end
   end

   always_comb begin
      logic [2:0]  lead;
      logic [5:0]  u;
      logic [30:0] keep;
      logic        guard;
      logic        sticky;
      logic [31:0] rounded;
      logic [31:0] trunc;
      lead = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (sum_ff.sum[41 + i]) begin
            lead = 3'(i);
         end
      end
      u       = 6'd18 + 6'(lead);
      keep    = 31'(sum_ff.sum >> u);
      guard   = sum_ff.sum[u - 6'd1];
      sticky  = |(sum_ff.sum & ((49'd1 << (u - 6'd1)) - 49'd1));
      rounded = 32'(keep) + 32'(guard & (sticky | keep[0]));
      trunc   = rounded >> (6'd23 - 6'(lead));
      if (sum_ff.ctrl.fmode && (sum_ff.ctrl.nbytes == NB_ONE)) begin
         word_in = sum_ff.nan ? 32'd0 : {24'd0, trunc[7:0]};
      end else begin
         word_in = sum_ff.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (adv) begin
         sum_valid_ff <= in_valid;
         valid_ff     <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff  <= sum_in;
         word_ff <= word_in;
         last_ff <= sum_ff.ctrl.last;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// ===== sv/pcm_sample_formatter.sv =====
// Top level of the PCM sample formatter: configuration registers and the
// five-stage conversion pipeline.
// Depends on psf_pkg, psf_decode, psf_multiply, psf_round and psf_pack.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_sample_bits, req_last_in
//   rsp      out        rsp_valid/rsp_stall  rsp_pcm_word, rsp_last_out
//   csr      in         csr_write            csr_index, csr_data
//
// One transaction enters per cycle while req_stall is low; its result is registered
// in turn by the decode, multiply, round, offset and pack stages.
// The synchronous reset empties the pipeline and restores two output bytes,
// integer mode and a 16-bit source depth.
// While a result waits under rsp_stall the whole pipeline holds and req_stall
// is raised in the same cycle.
`default_nettype none

module pcm_sample_formatter import psf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_sample_bits,
   input  wire logic        req_last_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_pcm_word,
   output logic             rsp_last_out,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [5:0]  csr_data
);

   logic [2:0] out_bytes_ff;
   logic       float_mode_ff;
   logic [5:0] source_bits_ff;
   logic       adv;
   logic       dec_valid;
   dec_type    dec_data;
   logic       mul_valid;
   mul_type    mul_data;
   logic       rnd_valid;
   rnd_type    rnd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_bytes_ff   <= RESET_OUT_BYTES;
         float_mode_ff  <= 1'b0;
         source_bits_ff <= RESET_SOURCE_BITS;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OUT_BYTES:   out_bytes_ff   <= csr_data[2:0];
            CSR_FLOAT_MODE:  float_mode_ff  <= csr_data[0];
            CSR_SOURCE_BITS: source_bits_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = rsp_valid && rsp_stall;
   assign adv       = !req_stall;

   psf_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .in_bits     (req_sample_bits),
      .in_last     (req_last_in),
      .out_bytes   (out_bytes_ff),
      .float_mode  (float_mode_ff),
      .source_bits (source_bits_ff),
      .out_valid   (dec_valid),
      .out_data    (dec_data)
   );

   psf_multiply u_multiply (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dec_valid),
      .in_data   (dec_data),
      .out_valid (mul_valid),
      .out_data  (mul_data)
   );

   psf_round u_round (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mul_valid),
      .in_data   (mul_data),
      .out_valid (rnd_valid),
      .out_data  (rnd_data)
   );

   psf_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (rnd_valid),
      .in_data   (rnd_data),
      .out_valid (rsp_valid),
      .out_word  (rsp_pcm_word),
      .out_last  (rsp_last_out)
   );

endmodule

`default_nettype wire

// ===== sv/psf_checker.sv =====
// Port-level checks for the PCM sample formatter and the bind that
// attaches them to the top level. Depends on pcm_sample_formatter's ports.
`default_nettype none

module psf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_pcm_word,
   input wire logic        rsp_last_out
);

   // A result held under stall keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pcm_word)
                                && $stable(rsp_last_out))
      else $error("result changed while stalled");

   // The input side is only held back by a waiting result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   // A transaction accepted without stall reaches the output if rsp_stall stays low while it passes the pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      ##1 !rsp_stall |=> rsp_valid)
      else $error("result missing after pipeline latency");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pcm_sample_formatter psf_checker u_psf_checker (.*);

`default_nettype wire
